// ===== hdl/lome_pkg.sv =====
// ----------------------------------------------------------------------------
// lome_pkg
// shared types, constants and codes of the limit order matching engine
// ----------------------------------------------------------------------------
package lome_pkg;

   localparam int BOOK_DEPTH_DEF = 32;
   localparam int NUM_INSTR_DEF  = 5;
   localparam int MAX_RESULTS    = 64;
   localparam int MIN_QTY        = 10;
   localparam int MAX_QTY        = 1000;
   localparam int MAX_ID_LEN     = 7;

   localparam logic [1:0] SIDE_BUY  = 2'd1;
   localparam logic [1:0] SIDE_SELL = 2'd2;

   // reject reason bit positions
   localparam int RSN_ID     = 0;
   localparam int RSN_INSTR  = 1;
   localparam int RSN_PRICE  = 2;
   localparam int RSN_SIDE   = 3;
   localparam int RSN_QTY    = 4;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_REJECTED = 3'd1,
      ST_FILL     = 3'd2,
      ST_PFILL    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MATCH_RD,
      S_MATCH_EVAL,
      S_MATCH_INC,
      S_MATCH_REST,
      S_PLACE,
      S_INS_RD,
      S_INS_EVAL,
      S_INS_DONE,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [55:0]        client_id;
      logic [3:0]         id_length;
      logic [2:0]         instrument;
      logic [1:0]         side;
      logic signed [15:0] quantity;
      logic signed [31:0] price;
   } order_type;

   typedef struct packed {
      logic [31:0]        order_number;
      logic [55:0]        client_id;
      logic [3:0]         id_length;
      logic [2:0]         instrument;
      logic [1:0]         side;
      status_type         status;
      logic signed [15:0] quantity;
      logic signed [31:0] price;
      logic [4:0]         reasons;
   } report_type;

   typedef struct packed {
      logic signed [31:0] price;
      logic [9:0]         quantity;
      logic [31:0]        order_number;
      logic [55:0]        client_id;
      logic [2:0]         id_length;
   } entry_type;

   // sequencer to output stage
   typedef struct packed {
      logic emit;
      logic flush;
   } seq_ctl_type;

   // output stage to sequencer
   typedef struct packed {
      logic emit_ready;
      logic flush_ready;
   } out_ctl_type;

endpackage

// ===== hdl/lome_ram.sv =====
// ----------------------------------------------------------------------------
// lome_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lome_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/lome_seq.sv =====
// ----------------------------------------------------------------------------
// lome_seq
// order sequencer: validation, matching walk and sorted insertion on the ram
// ----------------------------------------------------------------------------
module lome_seq #(
   parameter int BOOK_DEPTH      = lome_pkg::BOOK_DEPTH_DEF,
   parameter int NUM_INSTRUMENTS = lome_pkg::NUM_INSTR_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lome_pkg::order_type   req_order,
   output lome_pkg::report_type  rpt,
   output lome_pkg::seq_ctl_type ctl,
   input  lome_pkg::out_ctl_type octl
);

   localparam int NUM_BOOKS = 2 * NUM_INSTRUMENTS;
   localparam int BOOK_W    = $clog2(NUM_BOOKS);
   localparam int IDX_W     = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BOOK_DEPTH + 1);
   localparam int SLOTS     = NUM_BOOKS * BOOK_DEPTH;
   localparam int ADDR_W    = $clog2(SLOTS);
   localparam int ENT_W     = $bits(lome_pkg::entry_type);

   lome_pkg::seq_state_type state_ff, state_in;
   lome_pkg::order_type     order_ff, order_in;
   lome_pkg::entry_type     ent_ff, ent_in;
   logic [31:0]             counter_ff, counter_in;
   logic [9:0]              rem_ff, rem_in;
   logic                    matched_ff, matched_in;
   logic [6:0]              nrep_ff, nrep_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff [NUM_BOOKS];
   logic [CNT_W-1:0]        cnt_in [NUM_BOOKS];
   logic [IDX_W-1:0]        head_ff [NUM_BOOKS];
   logic [IDX_W-1:0]        head_in [NUM_BOOKS];

   logic                    is_buy;
   logic [BOOK_W-1:0]       own_book, opp_book, bsel;
   logic [CNT_W-1:0]        cur_cnt;
   logic [IDX_W-1:0]        cur_head;
   logic [CNT_W-1:0]        rd_off, wr_off;
   logic [ADDR_W-1:0]       rd_addr, wr_addr, book_base;
   logic                    rd_en, wr_en;
   lome_pkg::entry_type     wr_data, rd_ent, new_ent;
   logic [ENT_W-1:0]        rd_raw;
   logic [4:0]              reasons;
   logic [17:0]             qprod;
   logic [9:0]              qlow, qquo, qback;
   logic [IDX_W:0]          head_inc;
   logic [9:0]              rq, mq;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] h,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W+IDX_W:0] s;
      s = (CNT_W+IDX_W+1)'(h) + (CNT_W+IDX_W+1)'(off);
      if (s >= (CNT_W+IDX_W+1)'(BOOK_DEPTH)) begin
         s = s - (CNT_W+IDX_W+1)'(BOOK_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   lome_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_book_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent   = lome_pkg::entry_type'(rd_raw);
   assign is_buy   = (order_ff.side == lome_pkg::SIDE_BUY);
   assign own_book = BOOK_W'({order_ff.instrument, !is_buy});
   assign opp_book = own_book ^ BOOK_W'(1);
   assign bsel     = (state_ff == lome_pkg::S_PLACE || state_ff == lome_pkg::S_INS_RD ||
                      state_ff == lome_pkg::S_INS_EVAL || state_ff == lome_pkg::S_INS_DONE)
                     ? own_book : opp_book;
   assign cur_cnt   = cnt_ff[bsel];
   assign cur_head  = head_ff[bsel];
   assign book_base = ADDR_W'(bsel * BOOK_DEPTH);
   assign rd_addr   = book_base + ADDR_W'(wrap_idx(cur_head, rd_off));
   assign wr_addr   = book_base + ADDR_W'(wrap_idx(cur_head, wr_off));
   assign head_inc  = (IDX_W+1)'(cur_head) + (IDX_W+1)'(1);

   // quantity step check by reciprocal multiply, exact for values below 1024
   assign qlow  = order_ff.quantity[9:0];
   assign qprod = 18'(qlow) * 18'd205;
   assign qquo  = 10'(qprod[17:11]);
   assign qback = 10'({qquo, 3'b000}) + 10'({qquo, 1'b0});

   always_comb begin
      reasons = '0;
      if (order_ff.id_length < 4'd1 || order_ff.id_length > 4'(lome_pkg::MAX_ID_LEN)) begin
         reasons[lome_pkg::RSN_ID] = 1'b1;
      end
      if ({1'b0, order_ff.instrument} >= 4'(NUM_INSTRUMENTS)) begin
         reasons[lome_pkg::RSN_INSTR] = 1'b1;
      end
      if (order_ff.price <= 32'sd0) begin
         reasons[lome_pkg::RSN_PRICE] = 1'b1;
      end
      if (order_ff.side != lome_pkg::SIDE_BUY && order_ff.side != lome_pkg::SIDE_SELL) begin
         reasons[lome_pkg::RSN_SIDE] = 1'b1;
      end
      if (order_ff.quantity < 16'(lome_pkg::MIN_QTY) ||
          order_ff.quantity > 16'(lome_pkg::MAX_QTY) || qback != qlow) begin
         reasons[lome_pkg::RSN_QTY] = 1'b1;
      end
   end

   assign rq = ent_ff.quantity;
   assign mq = (rem_ff < rq) ? rem_ff : rq;

   always_comb begin
      new_ent.price        = order_ff.price;
      new_ent.quantity     = rem_ff;
      new_ent.order_number = counter_ff;
      new_ent.client_id    = order_ff.client_id;
      new_ent.id_length    = order_ff.id_length[2:0];
   end

   always_comb begin
      state_in   = state_ff;
      order_in   = order_ff;
      ent_in     = ent_ff;
      counter_in = counter_ff;
      rem_in     = rem_ff;
      matched_in = matched_ff;
      nrep_in    = nrep_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      head_in    = head_ff;
      req_ready  = 1'b0;
      ctl        = '0;
      rd_en      = 1'b0;
      rd_off     = '0;
      wr_en      = 1'b0;
      wr_off     = '0;
      wr_data    = new_ent;
      rpt.order_number = counter_ff;
      rpt.client_id    = order_ff.client_id;
      rpt.id_length    = order_ff.id_length;
      rpt.instrument   = order_ff.instrument;
      rpt.side         = order_ff.side;
      rpt.status       = lome_pkg::ST_NEW;
      rpt.quantity     = order_ff.quantity;
      rpt.price        = order_ff.price;
      rpt.reasons      = '0;

      case (state_ff)
         lome_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               order_in   = req_order;
               counter_in = counter_ff + 32'd1;
               nrep_in    = '0;
               matched_in = 1'b0;
               state_in   = lome_pkg::S_CHECK;
            end
         end
         lome_pkg::S_CHECK: begin
            rem_in = qlow;
            if (reasons != '0) begin
               rpt.status  = lome_pkg::ST_REJECTED;
               rpt.reasons = reasons;
               ctl.emit    = 1'b1;
               if (octl.emit_ready) begin
                  state_in = lome_pkg::S_FINISH;
               end
            end else begin
               state_in = lome_pkg::S_MATCH_RD;
            end
         end
         lome_pkg::S_MATCH_RD: begin
            if (rem_ff != '0 && cur_cnt != '0) begin
               rd_en    = 1'b1;
               state_in = lome_pkg::S_MATCH_EVAL;
            end else begin
               state_in = lome_pkg::S_PLACE;
            end
         end
         lome_pkg::S_MATCH_EVAL: begin
            ent_in = rd_ent;
            if (is_buy ? (order_ff.price < rd_ent.price) : (order_ff.price > rd_ent.price)) begin
               state_in = lome_pkg::S_PLACE;
            end else begin
               state_in = lome_pkg::S_MATCH_INC;
            end
         end
         lome_pkg::S_MATCH_INC: begin
            rpt.status   = (rem_ff <= rq) ? lome_pkg::ST_FILL : lome_pkg::ST_PFILL;
            rpt.quantity = 16'(mq);
            rpt.price    = ent_ff.price;
            ctl.emit     = 1'b1;
            if (octl.emit_ready) begin
               nrep_in  = nrep_ff + 7'd1;
               state_in = lome_pkg::S_MATCH_REST;
            end
         end
         lome_pkg::S_MATCH_REST: begin
            rpt.order_number = ent_ff.order_number;
            rpt.client_id    = ent_ff.client_id;
            rpt.id_length    = 4'(ent_ff.id_length);
            rpt.side         = is_buy ? lome_pkg::SIDE_SELL : lome_pkg::SIDE_BUY;
            rpt.status       = (rem_ff < rq) ? lome_pkg::ST_PFILL : lome_pkg::ST_FILL;
            rpt.quantity     = 16'(mq);
            rpt.price        = ent_ff.price;
            ctl.emit         = 1'b1;
            if (octl.emit_ready) begin
               nrep_in    = nrep_ff + 7'd1;
               matched_in = 1'b1;
               if (rem_ff >= rq) begin
                  // front order exhausted, pop it
                  head_in[bsel] = (head_inc >= (IDX_W+1)'(BOOK_DEPTH))
                                  ? '0 : head_inc[IDX_W-1:0];
                  cnt_in[bsel]  = cur_cnt - CNT_W'(1);
                  rem_in        = rem_ff - rq;
               end else begin
                  wr_en            = 1'b1;
                  wr_data          = ent_ff;
                  wr_data.quantity = rq - rem_ff;
                  rem_in           = '0;
               end
               state_in = lome_pkg::S_MATCH_RD;
            end
         end
         lome_pkg::S_PLACE: begin
            if (rem_ff == '0) begin
               state_in = lome_pkg::S_FINISH;
            end else if (cur_cnt < CNT_W'(BOOK_DEPTH)) begin
               idx_in   = cur_cnt;
               state_in = lome_pkg::S_INS_RD;
            end else if (nrep_ff < 7'(lome_pkg::MAX_RESULTS)) begin
               rpt.status   = lome_pkg::ST_FULL;
               rpt.quantity = 16'(rem_ff);
               ctl.emit     = 1'b1;
               if (octl.emit_ready) begin
                  state_in = lome_pkg::S_FINISH;
               end
            end else begin
               state_in = lome_pkg::S_FINISH;
            end
         end
         lome_pkg::S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = lome_pkg::S_INS_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_off   = idx_ff - CNT_W'(1);
               state_in = lome_pkg::S_INS_EVAL;
            end
         end
         lome_pkg::S_INS_EVAL: begin
            wr_en  = 1'b1;
            wr_off = idx_ff;
            if (is_buy ? (rd_ent.price < order_ff.price) : (rd_ent.price > order_ff.price)) begin
               wr_data  = rd_ent;
               idx_in   = idx_ff - CNT_W'(1);
               state_in = lome_pkg::S_INS_RD;
            end else begin
               state_in = lome_pkg::S_INS_DONE;
            end
         end
         lome_pkg::S_INS_DONE: begin
            ctl.emit = !matched_ff;
            if (matched_ff || octl.emit_ready) begin
               cnt_in[bsel] = cur_cnt + CNT_W'(1);
               state_in     = lome_pkg::S_FINISH;
            end
         end
         lome_pkg::S_FINISH: begin
            ctl.flush = 1'b1;
            if (octl.flush_ready) begin
               state_in = lome_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lome_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lome_pkg::S_IDLE;
         counter_ff <= '0;
         cnt_ff     <= '{default: '0};
         head_ff    <= '{default: '0};
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         cnt_ff     <= cnt_in;
         head_ff    <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff   <= order_in;
      ent_ff     <= ent_in;
      rem_ff     <= rem_in;
      matched_ff <= matched_in;
      nrep_ff    <= nrep_in;
      idx_ff     <= idx_in;
   end

`ifndef SYNTHESIS
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == lome_pkg::S_IDLE |-> !ctl.emit && !ctl.flush)
      else $error("report offered while idle");
   // only meaningful when the selected book exists (rejected orders may not name one)
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != lome_pkg::S_IDLE && {1'b0, bsel} < (BOOK_W+1)'(NUM_BOOKS)
      |-> cur_cnt <= CNT_W'(BOOK_DEPTH))
      else $error("book count beyond depth");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("read and write on the same slot");
`endif

endmodule

// ===== hdl/limit_order_matching_engine_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_matching_engine_core
// price-time priority matching of limit orders over per-instrument books
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    client id, length, instrument, side, qty, price
// rsp      out  rsp_valid/rsp_ready    report word, rsp_last on the final one
//
// a new order is accepted only once the previous one is finished; a rejected order
// is reported without touching the book, a valid order walks every matched resting
// order and then shifts resting orders one slot each during sorted insertion; the
// book ram, with one read and one write port, sets the pace
// reset is synchronous and clears the sequence counter and all book counts
// the book ram itself is not cleared: slots beyond a book's count are never read
// one report is held back so its last flag is known; stalls on rsp hold the walk
module limit_order_matching_engine_core #(
   parameter int BOOK_DEPTH      = lome_pkg::BOOK_DEPTH_DEF,
   parameter int NUM_INSTRUMENTS = lome_pkg::NUM_INSTR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [55:0]        req_client_id,
   input  logic [3:0]         req_id_length,
   input  logic [2:0]         req_instrument,
   input  logic [1:0]         req_side,
   input  logic signed [15:0] req_quantity,
   input  logic signed [31:0] req_price,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_order_number,
   output logic [55:0]        rsp_report_client_id,
   output logic [3:0]         rsp_report_id_length,
   output logic [2:0]         rsp_report_instrument,
   output logic [1:0]         rsp_report_side,
   output logic [2:0]         rsp_status,
   output logic signed [15:0] rsp_report_quantity,
   output logic signed [31:0] rsp_report_price,
   output logic [4:0]         rsp_reject_reasons,
   output logic               rsp_last
);

   lome_pkg::order_type   req_order;
   lome_pkg::report_type  rpt;
   lome_pkg::seq_ctl_type ctl;
   lome_pkg::out_ctl_type octl;

   // output word register and one held-back report
   lome_pkg::report_type  rsp_ff, rsp_in;
   lome_pkg::report_type  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  out_can_load;

   always_comb begin
      req_order.client_id  = req_client_id;
      req_order.id_length  = req_id_length;
      req_order.instrument = req_instrument;
      req_order.side       = req_side;
      req_order.quantity   = req_quantity;
      req_order.price      = req_price;
   end

   lome_seq #(
      .BOOK_DEPTH      (BOOK_DEPTH),
      .NUM_INSTRUMENTS (NUM_INSTRUMENTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_order (req_order),
      .rpt       (rpt),
      .ctl       (ctl),
      .octl      (octl)
   );

   assign out_can_load     = !rsp_valid_ff || rsp_ready;
   assign octl.emit_ready  = !pend_valid_ff || out_can_load;
   assign octl.flush_ready = out_can_load;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (ctl.emit && octl.emit_ready) begin
         // a newer report proves the held one was not the last
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = rpt;
         pend_valid_in = 1'b1;
      end else if (ctl.flush && octl.flush_ready && pend_valid_ff) begin
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      pend_ff     <= pend_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_order_number      = rsp_ff.order_number;
   assign rsp_report_client_id  = rsp_ff.client_id;
   assign rsp_report_id_length  = rsp_ff.id_length;
   assign rsp_report_instrument = rsp_ff.instrument;
   assign rsp_report_side       = rsp_ff.side;
   assign rsp_status            = rsp_ff.status;
   assign rsp_report_quantity   = rsp_ff.quantity;
   assign rsp_report_price      = rsp_ff.price;
   assign rsp_reject_reasons    = rsp_ff.reasons;
   assign rsp_last              = rsp_last_ff;

`ifndef SYNTHESIS
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.flush && octl.flush_ready |=> !pend_valid_ff)
      else $error("held report survived flush");
   a_flush_has_word: assert property (@(posedge clock) disable iff (reset)
      ctl.flush |-> pend_valid_ff)
      else $error("order finished without a report");
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("held report left behind at idle");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the limit order matching engine: orders are driven
// on req, every report word is checked in order against a price-time book
// model kept in a small scoreboard class
// ----------------------------------------------------------------------------

// book model and report store
class match_scoreboard;
   localparam int DEPTH = lome_pkg::BOOK_DEPTH_DEF;
   localparam int NINST = lome_pkg::NUM_INSTR_DEF;

   typedef struct {
      logic [31:0]        num;
      logic [55:0]        cid;
      logic [3:0]         len;
      logic [2:0]         instr;
      logic [1:0]         side;
      lome_pkg::status_type st;
      logic signed [15:0] qty;
      logic signed [31:0] price;
      logic [4:0]         rsn;
      logic               last;
   } report_rec;

   report_rec          pending[$];
   logic [31:0]        seq_num;
   int                 depth_of[2*NINST];
   logic signed [31:0] bk_price[2*NINST][DEPTH];
   int                 bk_qty[2*NINST][DEPTH];
   logic [31:0]        bk_num[2*NINST][DEPTH];
   logic [55:0]        bk_cid[2*NINST][DEPTH];
   logic [3:0]         bk_len[2*NINST][DEPTH];
   int                 mismatches;
   int                 reports_seen;
   int                 fills_seen;
   int                 full_seen;
   int                 rejects_seen;

   function new();
      seq_num = 0;
      mismatches = 0;
      reports_seen = 0;
      fills_seen = 0;
      full_seen = 0;
      rejects_seen = 0;
      foreach (depth_of[i]) depth_of[i] = 0;
   endfunction

   function void push(logic [31:0] n, logic [55:0] c, logic [3:0] l, logic [2:0] i,
                      logic [1:0] s, lome_pkg::status_type st, int q,
                      logic signed [31:0] p, logic [4:0] r);
      report_rec x;
      x.num = n; x.cid = c; x.len = l; x.instr = i; x.side = s; x.st = st;
      x.qty = q[15:0]; x.price = p; x.rsn = r; x.last = 1'b0;
      pending.insert(pending.size(), x);
   endfunction

   function void drop_front(int b);
      for (int k = 1; k < depth_of[b]; k++) begin
         bk_price[b][k-1] = bk_price[b][k];
         bk_qty[b][k-1] = bk_qty[b][k];
         bk_num[b][k-1] = bk_num[b][k];
         bk_cid[b][k-1] = bk_cid[b][k];
         bk_len[b][k-1] = bk_len[b][k];
      end
      depth_of[b]--;
   endfunction

   // accepted order: predict all its reports
   function void note_order(logic [55:0] cid, logic [3:0] len, logic [2:0] instr,
                            logic [1:0] side, logic signed [15:0] q,
                            logic signed [31:0] p);
      logic [4:0] rsn;
      int         own, opp, rem, made, pos, first;
      bit         buy, traded;
      logic [1:0] oside;
      rsn = 0;
      seq_num = seq_num + 1;
      first = pending.size();
      if (len < 1 || len > lome_pkg::MAX_ID_LEN) rsn[lome_pkg::RSN_ID] = 1;
      if (instr >= NINST) rsn[lome_pkg::RSN_INSTR] = 1;
      if (p <= 0) rsn[lome_pkg::RSN_PRICE] = 1;
      if (side != lome_pkg::SIDE_BUY && side != lome_pkg::SIDE_SELL)
         rsn[lome_pkg::RSN_SIDE] = 1;
      if (q < lome_pkg::MIN_QTY || q > lome_pkg::MAX_QTY || (q % 10) != 0)
         rsn[lome_pkg::RSN_QTY] = 1;
      if (rsn != 0) begin
         push(seq_num, cid, len, instr, side, lome_pkg::ST_REJECTED, q, p, rsn);
         pending[$].last = 1;
         return;
      end
      buy = (side == lome_pkg::SIDE_BUY);
      oside = buy ? lome_pkg::SIDE_SELL : lome_pkg::SIDE_BUY;
      own = instr * 2 + (buy ? 0 : 1);
      opp = own ^ 1;
      rem = q;
      made = 0;
      traded = 0;
      while (rem > 0 && depth_of[opp] > 0) begin
         if (buy ? (p < bk_price[opp][0]) : (p > bk_price[opp][0])) break;
         traded = 1;
         if (rem == bk_qty[opp][0]) begin
            push(seq_num, cid, len, instr, side, lome_pkg::ST_FILL, rem,
                 bk_price[opp][0], 0);
            push(bk_num[opp][0], bk_cid[opp][0], bk_len[opp][0], instr, oside,
                 lome_pkg::ST_FILL, rem, bk_price[opp][0], 0);
            drop_front(opp);
            rem = 0;
         end else if (rem < bk_qty[opp][0]) begin
            push(seq_num, cid, len, instr, side, lome_pkg::ST_FILL, rem,
                 bk_price[opp][0], 0);
            push(bk_num[opp][0], bk_cid[opp][0], bk_len[opp][0], instr, oside,
                 lome_pkg::ST_PFILL, rem, bk_price[opp][0], 0);
            bk_qty[opp][0] -= rem;
            rem = 0;
         end else begin
            push(seq_num, cid, len, instr, side, lome_pkg::ST_PFILL,
                 bk_qty[opp][0], bk_price[opp][0], 0);
            push(bk_num[opp][0], bk_cid[opp][0], bk_len[opp][0], instr, oside,
                 lome_pkg::ST_FILL, bk_qty[opp][0], bk_price[opp][0], 0);
            rem -= bk_qty[opp][0];
            drop_front(opp);
         end
         made += 2;
      end
      if (rem > 0) begin
         if (depth_of[own] < DEPTH) begin
            pos = 0;
            while (pos < depth_of[own] && !(buy ? (bk_price[own][pos] < p)
                                                : (bk_price[own][pos] > p)))
               pos++;
            for (int k = depth_of[own]; k > pos; k--) begin
               bk_price[own][k] = bk_price[own][k-1];
               bk_qty[own][k] = bk_qty[own][k-1];
               bk_num[own][k] = bk_num[own][k-1];
               bk_cid[own][k] = bk_cid[own][k-1];
               bk_len[own][k] = bk_len[own][k-1];
            end
            bk_price[own][pos] = p;
            bk_qty[own][pos] = rem;
            bk_num[own][pos] = seq_num;
            bk_cid[own][pos] = cid;
            bk_len[own][pos] = {1'b0, len[2:0]};
            depth_of[own]++;
            if (!traded) begin
               push(seq_num, cid, len, instr, side, lome_pkg::ST_NEW, q, p, 0);
               made++;
            end
         end else if (made < lome_pkg::MAX_RESULTS) begin
            push(seq_num, cid, len, instr, side, lome_pkg::ST_FULL, rem, p, 0);
            made++;
         end
      end
      if (pending.size() > first) pending[$].last = 1;
   endfunction

   // accepted report word: compare with the oldest prediction
   function void check_report(logic [31:0] n, logic [55:0] c, logic [3:0] l,
                              logic [2:0] i, logic [1:0] s, logic [2:0] st,
                              logic signed [15:0] q, logic signed [31:0] p,
                              logic [4:0] r, logic lst);
      report_rec e;
      reports_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected report word, order %0d", n);
         return;
      end
      e = pending.pop_front();
      if (st == lome_pkg::ST_FILL || st == lome_pkg::ST_PFILL) fills_seen++;
      if (st == lome_pkg::ST_FULL) full_seen++;
      if (st == lome_pkg::ST_REJECTED) rejects_seen++;
      if (n !== e.num || c !== e.cid || l !== e.len || i !== e.instr || s !== e.side ||
          st !== e.st || q !== e.qty || p !== e.price || r !== e.rsn || lst !== e.last)
      begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch exp: num=%0d cid=%h len=%0d ins=%0d side=%0d st=%0d",
                     e.num, e.cid, e.len, e.instr, e.side, e.st);
            $display("   qty=%0d px=%0d rsn=%b last=%b", e.qty, e.price, e.rsn, e.last);
            $display("mismatch act: num=%0d cid=%h len=%0d ins=%0d side=%0d st=%0d",
                     n, c, l, i, s, st);
            $display("   qty=%0d px=%0d rsn=%b last=%b", q, p, r, lst);
         end
      end
   endfunction
endclass

module tb_top;

   // watchdog: limit on consecutive cycles with no accepted request or report word
   localparam int IDLE_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [55:0]        req_client_id;
   logic [3:0]         req_id_length;
   logic [2:0]         req_instrument;
   logic [1:0]         req_side;
   logic signed [15:0] req_quantity;
   logic signed [31:0] req_price;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [31:0]        rsp_order_number;
   logic [55:0]        rsp_report_client_id;
   logic [3:0]         rsp_report_id_length;
   logic [2:0]         rsp_report_instrument;
   logic [1:0]         rsp_report_side;
   logic [2:0]         rsp_status;
   logic signed [15:0] rsp_report_quantity;
   logic signed [31:0] rsp_report_price;
   logic [4:0]         rsp_reject_reasons;
   logic               rsp_last;

   match_scoreboard book = new();
   int  idle_cycles;
   int  orders_sent;
   bit  stall_free;      // receiver never stalls while set

   limit_order_matching_engine_core i_dut (.*);

   always begin
      clock = 1'b0; #1;
      clock = 1'b1; #1;
   end

   // receiver: stalls follow a pseudo-random shift register pattern, or none at all in quiet stretches
   logic [15:0] stall_pattern;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_pattern <= 16'b1011_0111_1100_1110;
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15] ^ stall_pattern[3]};
         rsp_ready <= stall_free ? 1'b1 : stall_pattern[0];
      end
   end

   // monitor: check accepted report words, watchdog on accepted-nothing cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            book.check_report(rsp_order_number, rsp_report_client_id,
                              rsp_report_id_length, rsp_report_instrument,
                              rsp_report_side, rsp_status, rsp_report_quantity,
                              rsp_report_price, rsp_reject_reasons, rsp_last);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d words outstanding", book.pending.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // drive one order word and hold it until accepted
   task automatic send_order(logic [55:0] cid, logic [3:0] len, logic [2:0] instr,
                             logic [1:0] side, logic signed [15:0] q,
                             logic signed [31:0] p);
      req_valid <= 1'b1;
      req_client_id <= cid;
      req_id_length <= len;
      req_instrument <= instr;
      req_side <= side;
      req_quantity <= q;
      req_price <= p;
      do @(posedge clock); while (!req_ready);
      book.note_order(cid, len, instr, side, q, p);
      orders_sent++;
   endtask

   task automatic pause(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // well-formed order on a small price band so books cross and fill often
   task automatic send_good(logic [2:0] instr, logic [1:0] side, int qty, int px);
      send_order(56'({$urandom, $urandom}), 4'($urandom_range(1, 7)), instr, side,
                 16'(qty), 32'(px));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      logic [1:0] sd;
      reset = 1'b1;
      req_valid = 1'b0;
      req_client_id = '0;
      req_id_length = '0;
      req_instrument = '0;
      req_side = '0;
      req_quantity = '0;
      req_price = '0;
      stall_free = 1'b1;
      idle_cycles = 0;
      orders_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every reject reason alone, then all at once
      send_order(56'hFF_FFFF_FFFF_FFFF, 4'd0, 3'd0, lome_pkg::SIDE_BUY, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd15, 3'd0, lome_pkg::SIDE_BUY, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd1, 3'd7, lome_pkg::SIDE_BUY, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd1, 3'd5, lome_pkg::SIDE_SELL, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'sd100, 32'sd0);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'sd100, 32'h8000_0000);
      send_order(56'h41, 4'd1, 3'd0, 2'd0, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, 2'd3, 16'sd100, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'sd1010, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'sd15, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'h8000, 32'sd500);
      send_order(56'h41, 4'd1, 3'd0, lome_pkg::SIDE_BUY, 16'sd0, 32'sd500);
      send_order('0, 4'd8, 3'd6, 2'd3, 16'sh7FFF, -32'sd1);
      // new orders at the quantity and price extremes, then matching
      send_order(56'hAA_5555_AAAA_5555, 4'd7, 3'd4, lome_pkg::SIDE_SELL, 16'sd10,
                 32'sh7FFF_FFFF);
      send_order(56'h42, 4'd1, 3'd4, lome_pkg::SIDE_SELL, 16'sd1000, 32'sd1);
      send_order(56'h43, 4'd2, 3'd4, lome_pkg::SIDE_SELL, 16'sd50, 32'sd100);
      // incoming smaller
      send_order(56'h44, 4'd3, 3'd4, lome_pkg::SIDE_BUY, 16'sd500, 32'sd1);
      // equal quantities
      send_order(56'h45, 4'd3, 3'd4, lome_pkg::SIDE_BUY, 16'sd500, 32'sd1);
      // incoming larger, rests
      send_order(56'h46, 4'd4, 3'd4, lome_pkg::SIDE_BUY, 16'sd100, 32'sd100);
      // sweeps the buy
      send_order(56'h47, 4'd5, 3'd4, lome_pkg::SIDE_SELL, 16'sd1000, 32'sd50);
      drain();

      // fill one book side to capacity, then overflow it
      stall_free = 1'b0;
      for (int k = 0; k < 34; k++)
         send_good(3'd2, lome_pkg::SIDE_BUY, 10 * $urandom_range(1, 100),
                   $urandom_range(1, 40));
      // one big sell sweeping many buys, then a sweep whose remainder hits a full side
      send_good(3'd2, lome_pkg::SIDE_SELL, 1000, 1);
      drain();
      for (int k = 0; k < 32; k++) send_good(3'd3, lome_pkg::SIDE_SELL, 10, 1000);
      for (int k = 0; k < 32; k++) send_good(3'd3, lome_pkg::SIDE_BUY, 10, 1);
      send_good(3'd3, lome_pkg::SIDE_BUY, 1000, 1000);  // 64 words, full book drops the rest
      // sender holds off until every report has come back
      drain();
      repeat (20) @(posedge clock);

      // random: bursts of mostly valid orders with random gaps
      while (orders_sent < 220) begin
         burst = $urandom_range(1, 12);
         stall_free = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < burst; k++) begin
            sd = 2'($urandom_range(1, 2));
            if ($urandom_range(0, 9) == 0)
               send_order(56'({$urandom, $urandom}), 4'($urandom), 3'($urandom),
                          2'($urandom), 16'($urandom), 32'($urandom));
            else
               send_good(3'($urandom_range(0, 4)), sd, 10 * $urandom_range(1, 100),
                         $urandom_range(90, 110));
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 30));
      end
      drain();
      repeat (300) @(posedge clock);

      $display("%0d orders, %0d report words: %0d trade, %0d rejected, %0d book full",
               orders_sent, book.reports_seen, book.fills_seen, book.rejects_seen,
               book.full_seen);
      if (book.mismatches == 0 && book.pending.size() == 0)
         $display("tb: success");
      else begin
         $display("%0d mismatches, %0d words missing", book.mismatches,
                  book.pending.size());
         $display("tb: failure");
      end
      $finish;
   end
endmodule
